>>> rtl/core/pedt_pkg.sv
// ----------------------------------------------------------------------------
// pedt_pkg: shared types and constants of the parabola envelope line unit
// Holds the channel beat structs and the sequencer states.
// ----------------------------------------------------------------------------
package pedt_pkg;

    localparam int LINE_LEN   = 64;
    localparam int VALUE_BITS = 32;
    localparam int IDX_W      = $clog2(LINE_LEN);
    localparam int CNT_W      = $clog2(LINE_LEN + 1);
    localparam int NUM_W      = VALUE_BITS + 2 * IDX_W + 3;
    localparam int DEN_W      = IDX_W + 2;
    localparam int BND_W      = $clog2(LINE_LEN + 1);

    typedef struct packed {
        logic [31:0] sample;
        logic        line_end;
        logic        border_left;
        logic        border_right;
    } in_beat_t;

    typedef struct packed {
        logic [31:0] distance_sq;
        logic        out_last;
    } out_beat_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RD,
        ST_CMP,
        ST_PUSH,
        ST_ERD,
        ST_EWALK,
        ST_EMIT
    } state_t;

endpackage

>>> rtl/core/parabola_envelope_edt_line_unit.sv
// ----------------------------------------------------------------------------
// parabola_envelope_edt_line_unit: 1-D squared distance transform of a line
// Lower envelope of parabolas with exact rational boundaries.
// ----------------------------------------------------------------------------
// One beat per line element is taken. Each element pushes its parabola on an
// envelope stack held in memories: the envelope top is read, the new
// boundary compared by cross multiplication and the top dropped until the
// boundary lies beyond it. Each compare step runs through ST_RD (fetch the
// vertex sample and boundary), ST_CMP (form the new boundary) and ST_PUSH
// (compare), and the last step also pushes, so the input stays stalled
// until the step that pushes is done and each pop adds another step. On
// the element that ends the line, or the sixty-fourth, the unit stops
// taking beats and walks the envelope once, emitting one result per element
// in order; each result passes ST_ERD, ST_EWALK and ST_EMIT, each envelope
// boundary crossed adds an ST_ERD and ST_EWALK, and a result waits while
// the output is stalled. The output register lets a finished beat wait while
// the sequencer carries on. All stores are synchronous with registered reads.
module parabola_envelope_edt_line_unit
    import pedt_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_stall,
    input  in_beat_t  in_data,
    output logic      out_valid,
    input  logic      out_stall,
    output out_beat_t out_data
);

    // memories
    logic [VALUE_BITS-1:0]   line_mem [LINE_LEN];
    logic [IDX_W-1:0]        vtx_mem  [LINE_LEN];
    logic signed [NUM_W-1:0] num_mem  [LINE_LEN+1];
    logic [DEN_W-1:0]        den_mem  [LINE_LEN+1];

    state_t state_reg, state_next;
    logic [CNT_W-1:0] fill_reg, fill_next;
    logic [1:0]       bord_reg, bord_next;
    logic [IDX_W-1:0] top_reg, top_next;
    logic [IDX_W-1:0] k_reg, k_next;
    logic [IDX_W-1:0] pos_reg, pos_next;
    logic [VALUE_BITS-1:0] val_reg, val_next;
    logic [IDX_W-1:0] i_reg, i_next;
    logic              ov_reg, ov_next;
    out_beat_t         od_reg, od_next;

    // read data
    logic [IDX_W-1:0]        vtx_rd;
    logic signed [NUM_W-1:0] num_rd;
    logic [DEN_W-1:0]        den_rd;
    logic [VALUE_BITS-1:0]   line_rd;
    logic [IDX_W-1:0]        vtx_ra;
    logic [BND_W-1:0]        bnd_ra;
    logic [IDX_W-1:0]        line_ra;
    logic [IDX_W-1:0]        q_reg, q_next;

    // writes
    logic                    line_we, vtx_we, bnd_we;
    logic [IDX_W-1:0]        line_wa, vtx_wa;
    logic [BND_W-1:0]        bnd_wa;
    logic [VALUE_BITS-1:0]   line_wd;
    logic [IDX_W-1:0]        vtx_wd;
    logic signed [NUM_W-1:0] num_wd;
    logic [DEN_W-1:0]        den_wd;

    // candidate boundary registers (product computed per step)
    logic signed [NUM_W-1:0] sn_reg, sn_next;
    logic [DEN_W-1:0]        sd_reg, sd_next;

    always_ff @(posedge clk)
    begin
        if (line_we) line_mem[line_wa] <= line_wd;
        if (vtx_we)  vtx_mem[vtx_wa]   <= vtx_wd;
        if (bnd_we)
        begin
            num_mem[bnd_wa] <= num_wd;
            den_mem[bnd_wa] <= den_wd;
        end
        vtx_rd  <= vtx_mem[vtx_ra];
        num_rd  <= num_mem[bnd_ra];
        den_rd  <= den_mem[bnd_ra];
        line_rd <= line_mem[line_ra];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            fill_reg  <= '0;
            bord_reg  <= '0;
            top_reg   <= '0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            fill_reg  <= fill_next;
            bord_reg  <= bord_next;
            top_reg   <= top_next;
            ov_reg    <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        k_reg   <= k_next;
        pos_reg <= pos_next;
        val_reg <= val_next;
        i_reg   <= i_next;
        od_reg  <= od_next;
        sn_reg  <= sn_next;
        sd_reg  <= sd_next;
        q_reg   <= q_next;
    end

    assign out_valid = ov_reg;
    assign out_data  = od_reg;
    assign in_stall  = (state_reg != ST_IDLE);

    // saturate the incoming sample to the value range
    logic [VALUE_BITS-1:0] samp_sat;
    always_comb
    begin
        if (VALUE_BITS >= 32)
            samp_sat = VALUE_BITS'(in_data.sample);
        else if ((in_data.sample >> VALUE_BITS) != 32'd0)
            samp_sat = '1;
        else
            samp_sat = VALUE_BITS'(in_data.sample);
    end

    // meeting point of new parabola pos with vertex p (value fp)
    logic signed [NUM_W-1:0] mp_num;
    logic [DEN_W-1:0]        mp_den;
    logic signed [IDX_W+1:0] mp_dr, mp_sr;
    always_comb
    begin
        mp_dr  = $signed({2'b00, pos_reg}) - $signed({2'b00, vtx_rd});
        mp_sr  = $signed({2'b00, pos_reg}) + $signed({2'b00, vtx_rd});
        mp_num = $signed(NUM_W'({1'b0, val_reg})) - $signed(NUM_W'({1'b0, line_rd}))
                 + NUM_W'(mp_dr * mp_sr);
        mp_den = DEN_W'({mp_dr, 1'b0});
    end

    // pop test: sn * den[k] <= num[k] * sd
    logic signed [NUM_W+DEN_W:0] lhs, rhs;
    assign lhs = sn_reg * $signed({1'b0, den_rd});
    assign rhs = num_rd * $signed({1'b0, sd_reg});

    // emission: advance while num[k+1] < i * den[k+1]
    logic signed [NUM_W-1:0] ith;
    assign ith = $signed(NUM_W'({1'b0, i_reg} * den_rd));

    // emission value
    logic [IDX_W-1:0]  dq;
    logic [VALUE_BITS+1:0] ev, clip_l, clip_r, ev_c;
    logic [CNT_W-1:0]  rem;
    always_comb
    begin
        dq     = (i_reg > q_reg) ? (i_reg - q_reg) : (q_reg - i_reg);
        ev     = (VALUE_BITS+2)'(dq * dq) + (VALUE_BITS+2)'(line_rd);
        clip_l = (VALUE_BITS+2)'(({1'b0, i_reg} + 1'b1) * ({1'b0, i_reg} + 1'b1));
        rem    = fill_reg - CNT_W'(i_reg);
        clip_r = (VALUE_BITS+2)'(rem * rem);
        ev_c   = ev;
        if (bord_reg[0] && clip_l < ev_c) ev_c = clip_l;
        if (bord_reg[1] && clip_r < ev_c) ev_c = clip_r;
        if (ev_c > (VALUE_BITS+2)'({VALUE_BITS{1'b1}})) ev_c = (VALUE_BITS+2)'({VALUE_BITS{1'b1}});
        if (ev_c > (VALUE_BITS+2)'(33'hFFFFFFFF)) ev_c = (VALUE_BITS+2)'(33'hFFFFFFFF);
    end

    always_comb
    begin
        state_next = state_reg;
        fill_next  = fill_reg;
        bord_next  = bord_reg;
        top_next   = top_reg;
        k_next     = k_reg;
        pos_next   = pos_reg;
        val_next   = val_reg;
        i_next     = i_reg;
        od_next    = od_reg;
        sn_next    = sn_reg;
        sd_next    = sd_reg;
        q_next     = q_reg;
        ov_next    = ov_reg && out_stall;
        line_we = 1'b0; vtx_we = 1'b0; bnd_we = 1'b0;
        line_wa = pos_reg; line_wd = val_reg;
        vtx_wa = pos_reg; vtx_wd = pos_reg;
        bnd_wa = BND_W'(k_reg); num_wd = sn_reg; den_wd = sd_reg;
        vtx_ra = k_reg; bnd_ra = BND_W'(k_reg); line_ra = vtx_rd;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    pos_next = (fill_reg >= CNT_W'(LINE_LEN)) ? IDX_W'(LINE_LEN - 1)
                                                              : IDX_W'(fill_reg);
                    val_next = samp_sat;
                    line_we  = 1'b1;
                    line_wa  = pos_next;
                    line_wd  = samp_sat;
                    k_next   = top_reg;
                    i_next   = {IDX_W{in_data.line_end}};
                    if (pos_next == '0)
                    begin
                        bord_next = {in_data.border_right, in_data.border_left};
                        top_next  = '0;
                        vtx_we = 1'b1; vtx_wa = '0; vtx_wd = '0;
                        fill_next = CNT_W'(1);
                        if (in_data.line_end)
                        begin
                            i_next = '0; k_next = '0;
                            state_next = ST_ERD;
                        end
                    end
                    else
                    begin
                        vtx_ra = top_reg;
                        state_next = ST_RD;
                    end
                end
            end
            ST_RD:
            begin
                // vertex of k ready: fetch its sample and boundary
                line_ra = vtx_rd;
                bnd_ra  = BND_W'(k_reg);
                vtx_ra  = k_reg;
                state_next = ST_CMP;
            end
            ST_CMP:
            begin
                sn_next = mp_num;
                sd_next = mp_den;
                state_next = ST_PUSH;
                vtx_ra = k_reg;
                bnd_ra = BND_W'(k_reg);
            end
            ST_PUSH:
            begin
                if (k_reg != '0 && lhs <= rhs)
                begin
                    k_next = k_reg - 1'b1;
                    vtx_ra = k_next;
                    state_next = ST_RD;
                end
                else
                begin
                    k_next = k_reg + 1'b1;
                    vtx_we = 1'b1; vtx_wa = k_next; vtx_wd = pos_reg;
                    bnd_we = 1'b1; bnd_wa = BND_W'(k_next);
                    top_next = k_next;
                    fill_next = CNT_W'(pos_reg) + 1'b1;
                    if (i_reg[0] || fill_next >= CNT_W'(LINE_LEN))
                    begin
                        i_next = '0; k_next = '0;
                        state_next = ST_ERD;
                    end
                    else
                        state_next = ST_IDLE;
                end
            end
            ST_ERD:
            begin
                // read vertex k and boundary k+1
                vtx_ra = k_reg;
                bnd_ra = BND_W'(k_reg) + 1'b1;
                state_next = ST_EWALK;
            end
            ST_EWALK:
            begin
                line_ra = vtx_rd;
                q_next  = vtx_rd;
                if (k_reg < top_reg && num_rd < ith)
                begin
                    k_next = k_reg + 1'b1;
                    state_next = ST_ERD;
                end
                else
                    state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (!ov_reg || !out_stall)
                begin
                    ov_next = 1'b1;
                    od_next.distance_sq = 32'(ev_c);
                    od_next.out_last = (CNT_W'(i_reg) + 1'b1 == fill_reg);
                    if (od_next.out_last)
                    begin
                        fill_next = '0; bord_next = '0; top_next = '0;
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        i_next = i_reg + 1'b1;
                        state_next = ST_ERD;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

endmodule
